// ===== src/lss_pkg.sv =====
`default_nettype none

package lss_pkg;

    // Default sizing of the stack.
    localparam int LSS_DEPTH      = 16;
    localparam int LSS_DATA_WIDTH = 32;

    // Action codes carried in the input word.
    localparam logic [1:0] ACT_PUSH   = 2'd0;
    localparam logic [1:0] ACT_POP    = 2'd1;
    localparam logic [1:0] ACT_SEARCH = 2'd2;

    // Status codes carried in the result word.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    // Input word.
    typedef struct packed {
        logic        [1:0]  action;
        logic signed [31:0] value;
    } lss_cmd_t;

    // Result word.
    typedef struct packed {
        logic signed [31:0] popped_value;
        logic               found;
        logic signed [31:0] top_value;
        logic        [4:0]  entry_count;
        logic               is_empty;
        logic               is_full;
        logic        [1:0]  status;
    } lss_rsp_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WAIT,
        S_SEARCH,
        S_RESP
    } lss_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_cmd;
        logic exec;
        logic top_load;
        logic search_run;
        logic res_load;
    } lss_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] action;
        logic       pop_refill;
        logic       search_done;
        logic       out_free;
    } lss_sts_t;

endpackage

`default_nettype wire

// ===== src/lss_ctrl.sv =====
`default_nettype none

module lss_ctrl
    import lss_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cmd_valid,
    output logic          cmd_stall,
    input  wire lss_sts_t sts,
    output lss_ctl_t      ctl
);

    lss_state_t state_reg;
    lss_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.action == ACT_SEARCH)
                begin
                    state_next = S_SEARCH;
                end
                else if (sts.pop_refill)
                begin
                    state_next = S_POP_WAIT;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_POP_WAIT:
            begin
                state_next = S_RESP;
            end
            S_SEARCH:
            begin
                if (sts.search_done)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output decode.
    always_comb
    begin
        ctl       = '0;
        cmd_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_stall    = 1'b0;
                ctl.take_cmd = cmd_valid;
            end
            S_EXEC:
            begin
                ctl.exec = 1'b1;
            end
            S_POP_WAIT:
            begin
                ctl.top_load = 1'b1;
            end
            S_SEARCH:
            begin
                ctl.search_run = 1'b1;
            end
            S_RESP:
            begin
                ctl.res_load = sts.out_free;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/lss_dp.sv =====
`default_nettype none

module lss_dp
    import lss_pkg::*;
#(
    parameter int DEPTH      = LSS_DEPTH,
    parameter int DATA_WIDTH = LSS_DATA_WIDTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire lss_cmd_t cmd,
    input  wire lss_ctl_t ctl,
    output lss_sts_t      sts,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output lss_rsp_t      rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Stack storage: slot 0 is the bottom.
    logic [DATA_WIDTH-1:0] mem [DEPTH];

    lss_cmd_t              cmd_reg;
    logic [CW-1:0]         fill_reg;
    logic [CW-1:0]         idx_reg;
    logic                  cmp_valid_reg;
    logic [DATA_WIDTH-1:0] top_reg;
    logic [DATA_WIDTH-1:0] popped_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic                  found_reg;
    logic [1:0]            status_reg;
    logic                  out_valid_reg;
    lss_rsp_t              out_reg;

    logic [DATA_WIDTH-1:0] key;
    logic [31:0]           top32;
    logic [31:0]           popped32;
    logic [4:0]            count5;
    logic [CW-1:0]         fill_less2;
    logic                  is_full;
    logic                  is_empty;
    logic                  more;
    logic                  hit;
    logic                  wr_en;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  out_free;

    // Width fitting between the 32-bit fields and the stored width.
    generate
        if (DATA_WIDTH <= 32)
        begin : g_narrow
            assign key = cmd_reg.value[DATA_WIDTH-1:0];
            if (DATA_WIDTH == 32)
            begin : g_eq
                assign top32    = top_reg;
                assign popped32 = popped_reg;
            end
            else
            begin : g_ext
                assign top32    = {{(32-DATA_WIDTH){1'b0}}, top_reg};
                assign popped32 = {{(32-DATA_WIDTH){1'b0}}, popped_reg};
            end
        end
        else
        begin : g_wide
            assign key      = {{(DATA_WIDTH-32){1'b0}}, cmd_reg.value};
            assign top32    = top_reg[31:0];
            assign popped32 = popped_reg[31:0];
        end

        if (CW >= 5)
        begin : g_cnt_trunc
            assign count5 = fill_reg[4:0];
        end
        else
        begin : g_cnt_ext
            assign count5 = {{(5-CW){1'b0}}, fill_reg};
        end
    endgenerate

    // Stack flags and search progress.
    assign is_full    = (fill_reg == CW'(DEPTH));
    assign is_empty   = (fill_reg == '0);
    assign fill_less2 = fill_reg - CW'(2);
    assign more       = (idx_reg < fill_reg);
    assign hit        = cmp_valid_reg && (rd_data_reg == key);
    assign out_free   = !out_valid_reg || !rsp_stall;

    // Memory port control.
    assign wr_en   = ctl.exec && (cmd_reg.action == ACT_PUSH) && !is_full;
    assign rd_en   = (ctl.exec && sts.pop_refill) || (ctl.search_run && more);
    assign rd_addr = ctl.exec ? fill_less2[AW-1:0] : idx_reg[AW-1:0];

    // Status toward the controller.
    always_comb
    begin
        sts.action      = cmd_reg.action;
        sts.pop_refill  = (cmd_reg.action == ACT_POP) && (fill_reg >= CW'(2));
        sts.search_done = hit || (!more && !cmp_valid_reg);
        sts.out_free    = out_free;
    end

    // Memory write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[fill_reg[AW-1:0]] <= key;
        end
    end

    // Memory read port, registered.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Input word capture.
    always_ff @(posedge clk)
    begin
        if (ctl.take_cmd)
        begin
            cmd_reg <= cmd;
        end
    end

    // Fill level and search pipeline control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else if (ctl.exec)
        begin
            cmp_valid_reg <= 1'b0;
            unique case (cmd_reg.action)
                ACT_PUSH:
                begin
                    if (!is_full)
                    begin
                        fill_reg <= fill_reg + CW'(1);
                    end
                end
                ACT_POP:
                begin
                    if (!is_empty)
                    begin
                        fill_reg <= fill_reg - CW'(1);
                    end
                end
                default:
                begin
                    fill_reg <= fill_reg;
                end
            endcase
        end
        else if (ctl.search_run)
        begin
            cmp_valid_reg <= more;
        end
    end

    // Top copy, result fields and search index.
    always_ff @(posedge clk)
    begin
        if (ctl.exec)
        begin
            popped_reg <= '0;
            found_reg  <= 1'b0;
            status_reg <= ST_OK;
            idx_reg    <= '0;
            unique case (cmd_reg.action)
                ACT_PUSH:
                begin
                    if (is_full)
                    begin
                        status_reg <= ST_OVERFLOW;
                    end
                    else
                    begin
                        top_reg <= key;
                    end
                end
                ACT_POP:
                begin
                    if (is_empty)
                    begin
                        status_reg <= ST_UNDERFLOW;
                    end
                    else
                    begin
                        popped_reg <= top_reg;
                    end
                end
                default:
                begin
                    status_reg <= ST_OK;
                end
            endcase
        end
        else if (ctl.top_load)
        begin
            top_reg <= rd_data_reg;
        end
        else if (ctl.search_run)
        begin
            if (more)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (hit)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register word.
    always_ff @(posedge clk)
    begin
        if (ctl.res_load)
        begin
            out_reg.popped_value <= popped32;
            out_reg.found        <= found_reg;
            out_reg.top_value    <= is_empty ? '0 : top32;
            out_reg.entry_count  <= count5;
            out_reg.is_empty     <= is_empty;
            out_reg.is_full      <= is_full;
            out_reg.status       <= status_reg;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

`default_nettype wire

// ===== src/lifo_stack_with_search.sv =====
// Push, pop from an empty or single-entry stack and idle codes pass the states S_EXEC and
// S_RESP; a pop that leaves entries adds S_POP_WAIT to refill the top copy. A search
// reads one stored entry per cycle through the single memory read port until a match or
// the last entry. No new input word is taken until the result of the last one is queued.
// Reset clears the fill level and the handshake state; stored entries are not cleared.
`default_nettype none

module lifo_stack_with_search
    import lss_pkg::*;
#(
    parameter int DEPTH      = LSS_DEPTH,
    parameter int DATA_WIDTH = LSS_DATA_WIDTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cmd_valid,
    output logic          cmd_stall,
    input  wire lss_cmd_t cmd,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output lss_rsp_t      rsp
);

    lss_ctl_t ctl;
    lss_sts_t sts;

    // Sequencer.
    lss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    // Storage, search compare and output register.
    lss_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .ctl       (ctl),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

`ifndef ASSERT_OFF
    // A taken word blocks further input until its result is queued.
    a_stall_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("input taken while an earlier word was in progress");

    // An empty stack reports no top entry and a zero count.
    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.is_empty) |-> (rsp.top_value == '0 && rsp.entry_count == '0
            && !rsp.is_full))
        else $error("empty stack reported with a top entry or count");

    // Overflow is only reported against a full stack.
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == ST_OVERFLOW) |-> rsp.is_full)
        else $error("overflow reported on a stack that is not full");

    // Underflow is only reported against an empty stack and pops nothing.
    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == ST_UNDERFLOW) |-> (rsp.is_empty && rsp.popped_value == '0))
        else $error("underflow reported on a stack that holds entries");
`endif

endmodule

`default_nettype wire
